/* src/assert_macros.svh */
// assertion macros used by the rtl (hmbp_queue)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/hmbp_pkg.sv */
`default_nettype none
package hmbp_pkg;

    typedef enum logic [2:0]
    {
        PH_START = 3'd0,
        PH_HEAD  = 3'd1,
        PH_BODY  = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    localparam logic [3:0] FK_NONE     = 4'd0;
    localparam logic [3:0] FK_METHOD   = 4'd1;
    localparam logic [3:0] FK_PATH     = 4'd2;
    localparam logic [3:0] FK_QUERY    = 4'd3;
    localparam logic [3:0] FK_FRAGMENT = 4'd4;
    localparam logic [3:0] FK_VERSION  = 4'd5;
    localparam logic [3:0] FK_STATUS   = 4'd6;
    localparam logic [3:0] FK_REASON   = 4'd7;
    localparam logic [3:0] FK_NAME     = 4'd8;
    localparam logic [3:0] FK_VALUE    = 4'd9;
    localparam logic [3:0] FK_BODY     = 4'd10;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_START_END = 3'd1;
    localparam logic [2:0] EV_HEADER    = 3'd2;
    localparam logic [2:0] EV_BODY      = 3'd3;
    localparam logic [2:0] EV_DONE      = 3'd4;
    localparam logic [2:0] EV_ERROR     = 3'd5;

    localparam logic [2:0] SP_FIRST       = 3'd0;
    localparam logic [2:0] SP_SECOND      = 3'd1;
    localparam logic [2:0] SP_THIRD       = 3'd2;
    localparam logic [2:0] SP_FOURTH      = 3'd3;
    localparam logic [2:0] SP_FIFTH       = 3'd4;
    localparam logic [2:0] SP_BAD_STATUS  = 3'd5;
    localparam logic [2:0] SP_LATE_REASON = 3'd6;

    localparam logic [3:0] VC_TAG_DONE = 4'd5;
    localparam logic [3:0] VC_MAJOR    = 4'd6;
    localparam logic [3:0] VC_DOT      = 4'd7;
    localparam logic [3:0] VC_OK       = 4'd8;
    localparam logic [3:0] VC_BAD      = 4'd15;

    localparam logic [1:0] HP_NAME  = 2'd0;
    localparam logic [1:0] HP_GAP   = 2'd1;
    localparam logic [1:0] HP_VALUE = 2'd2;

    localparam logic [4:0] CL_MATCHED = 5'd14;
    localparam logic [4:0] CL_EMPTY   = 5'd16;
    localparam logic [4:0] CL_DIGITS  = 5'd17;
    localparam logic [4:0] CL_STOP    = 5'd18;
    localparam logic [4:0] CL_BAD     = 5'd19;
    localparam logic [4:0] NM_NONE    = 5'd31;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed
    {
        logic [2:0]  start_part;
        logic [3:0]  vcheck;
        logic [3:0]  vmajor;
        logic [7:0]  vminor;
        logic [15:0] status;
        logic [4:0]  nm_idx;
        logic [1:0]  hpart;
        logic [63:0] acc;
    } cls_state_t;

    typedef struct packed
    {
        logic [3:0] kind;
        cls_state_t st;
    } cls_res_t;

    typedef struct packed
    {
        logic        cr_valid;
        logic [3:0]  cr_kind;
        logic [7:0]  cr_version;
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [2:0]  event_code;
        logic [7:0]  version;
        logic [15:0] status;
        logic [63:0] length;
        logic        accepted;
    } entry_t;

    typedef struct packed
    {
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [2:0]  event_code;
        logic [7:0]  version;
        logic [15:0] status;
        logic [63:0] length;
        logic        accepted;
        logic        last;
    } beat_t;

    function automatic logic is_digit(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [7:0] proto_char(logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            default: c = 8'h2f;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6e;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2d;
            4'd8:    c = 8'h6c;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6e;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] version_out(cls_state_t s);
        return (s.vcheck == VC_OK) ? ({s.vmajor, 4'h0} | s.vminor) : 8'h00;
    endfunction

    function automatic cls_state_t version_feed(cls_state_t s, logic [7:0] b);
        cls_state_t r;
        logic [7:0]  maj_w;
        logic [11:0] min_w;
        r = s;
        maj_w = ({4'h0, s.vmajor} << 3) + ({4'h0, s.vmajor} << 1) + {4'h0, b[3:0]};
        min_w = ({4'h0, s.vminor} << 3) + ({4'h0, s.vminor} << 1) + {8'h00, b[3:0]};
        if (s.vcheck < VC_TAG_DONE)
        begin
            r.vcheck = (b == proto_char(s.vcheck[2:0])) ? s.vcheck + 4'd1 : VC_BAD;
        end
        else if (s.vcheck == VC_TAG_DONE)
        begin
            if (is_digit(b))
            begin
                r.vmajor = b[3:0];
                r.vcheck = VC_MAJOR;
            end
            else
                r.vcheck = VC_BAD;
        end
        else if (s.vcheck == VC_MAJOR)
        begin
            if (is_digit(b))
                r.vmajor = maj_w[3:0];
            else
                r.vcheck = (b == CH_DOT) ? VC_DOT : VC_BAD;
        end
        else if (s.vcheck == VC_DOT)
        begin
            if (is_digit(b))
            begin
                r.vminor = {4'h0, b[3:0]};
                r.vcheck = VC_OK;
            end
            else
                r.vcheck = VC_BAD;
        end
        else if (s.vcheck == VC_OK)
        begin
            if (is_digit(b))
                r.vminor = min_w[7:0];
            else
                r.vcheck = VC_BAD;
        end
        return r;
    endfunction

    function automatic cls_state_t value_feed(cls_state_t s, logic [7:0] b);
        cls_state_t r;
        logic [67:0] prod;
        r = s;
        prod = ({4'h0, s.acc} << 3) + ({4'h0, s.acc} << 1) + {64'd0, b[3:0]};
        if (s.nm_idx == CL_EMPTY)
        begin
            if (is_digit(b))
            begin
                r.acc    = {60'd0, b[3:0]};
                r.nm_idx = CL_DIGITS;
            end
            else
                r.nm_idx = CL_BAD;
        end
        else if (s.nm_idx == CL_DIGITS)
        begin
            if (!is_digit(b))
                r.nm_idx = CL_STOP;
            else if (prod[67:64] != 4'h0)
                r.nm_idx = CL_BAD;   // above 64 bits
            else
                r.acc = prod[63:0];
        end
        return r;
    endfunction

    function automatic cls_res_t classify(cls_state_t s, logic start, logic mode,
                                          logic [7:0] b);
        cls_res_t   r;
        logic [7:0] lc;
        logic [19:0] st_w;
        r.st = s;
        r.kind = FK_NONE;
        lc = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ? b + 8'd32 : b;
        st_w = ({4'h0, s.status} << 3) + ({4'h0, s.status} << 1) + {16'd0, b[3:0]};
        if (start && !mode)
        begin
            unique case (s.start_part)
                SP_FIRST:
                begin
                    if (b == CH_SP) r.st.start_part = SP_SECOND;
                    else r.kind = FK_METHOD;
                end
                SP_SECOND:
                begin
                    if (b == CH_SP) r.st.start_part = SP_FIFTH;
                    else if (b == CH_QMARK) r.st.start_part = SP_THIRD;
                    else if (b == CH_HASH) r.st.start_part = SP_FOURTH;
                    else r.kind = FK_PATH;
                end
                SP_THIRD:
                begin
                    if (b == CH_SP) r.st.start_part = SP_FIFTH;
                    else if (b == CH_HASH) r.st.start_part = SP_FOURTH;
                    else r.kind = FK_QUERY;
                end
                SP_FOURTH:
                begin
                    if (b == CH_SP) r.st.start_part = SP_FIFTH;
                    else r.kind = FK_FRAGMENT;
                end
                default:
                begin
                    r.st = version_feed(s, b);
                    r.kind = FK_VERSION;
                end
            endcase
        end
        else if (start)
        begin
            unique case (s.start_part)
                SP_FIRST:
                begin
                    if (b == CH_SP) r.st.start_part = SP_SECOND;
                    else
                    begin
                        r.st = version_feed(s, b);
                        r.kind = FK_VERSION;
                    end
                end
                SP_SECOND:
                begin
                    r.kind = FK_STATUS;
                    if (b == CH_SP)
                    begin
                        r.st.start_part = SP_LATE_REASON;
                        r.kind = FK_NONE;
                    end
                    else if (is_digit(b))
                    begin
                        r.st.status = {12'd0, b[3:0]};
                        r.st.start_part = SP_THIRD;
                    end
                    else
                        r.st.start_part = SP_BAD_STATUS;
                end
                SP_THIRD:
                begin
                    r.kind = FK_STATUS;
                    if (b == CH_SP)
                    begin
                        r.st.start_part = SP_FIFTH;
                        r.kind = FK_NONE;
                    end
                    else if (is_digit(b))
                        r.st.status = st_w[15:0];
                    else
                        r.st.start_part = SP_FOURTH;
                end
                SP_FOURTH, SP_BAD_STATUS:
                begin
                    if (b == CH_SP)
                        r.st.start_part = (s.start_part == SP_FOURTH) ? SP_FIFTH
                                                                       : SP_LATE_REASON;
                    else
                        r.kind = FK_STATUS;
                end
                default: r.kind = FK_REASON;
            endcase
        end
        else if (s.hpart == HP_NAME)
        begin
            if (b == CH_COLON)
            begin
                r.st.nm_idx = (s.nm_idx == CL_MATCHED) ? CL_EMPTY : NM_NONE;
                r.st.hpart = HP_GAP;
            end
            else
            begin
                if (s.nm_idx < CL_MATCHED)
                    r.st.nm_idx = (lc == cl_char(s.nm_idx[3:0])) ? s.nm_idx + 5'd1 : NM_NONE;
                else
                    r.st.nm_idx = NM_NONE;
                r.kind = FK_NAME;
            end
        end
        else if ((s.hpart == HP_GAP) && ((b == CH_SP) || (b == CH_TAB)))
        begin
            r.kind = FK_NONE;
        end
        else
        begin
            r.st = value_feed(s, b);
            r.st.hpart = HP_VALUE;
            r.kind = FK_VALUE;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/hmbp_front.sv */
`default_nettype none
module hmbp_front #(
    parameter int MAX_LINE = 8192
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              q_full,
    output logic              push,
    output hmbp_pkg::entry_t  push_entry
);
    import hmbp_pkg::*;

    localparam int LL_W = $clog2(MAX_LINE + 1);

    logic             mode_reg;
    phase_t           phase_reg, phase_next;
    logic [LL_W-1:0]  ll_reg, ll_next;
    logic             crp_reg, crp_next;
    cls_state_t       st_reg, st_next;
    logic [63:0]      cl_reg, cl_next;
    logic [63:0]      rem_reg, rem_next;
    cls_res_t         r_cr, r_byte;
    logic             empty_line, line_ok;
    logic [3:0]       kind;
    logic [2:0]       ev;
    entry_t           ent;

    assign s_tready   = !q_full;
    assign push       = s_tvalid && s_tready;
    assign push_entry = ent;

    always_comb
    begin
        phase_next = phase_reg;
        ll_next    = ll_reg;
        crp_next   = crp_reg;
        st_next    = st_reg;
        cl_next    = cl_reg;
        rem_next   = rem_reg;
        if (s_tuser)
        begin
            phase_next = PH_START;
            ll_next    = '0;
            crp_next   = 1'b0;
            st_next    = '0;
            cl_next    = '0;
            rem_next   = '0;
        end
        ent        = '0;
        kind       = FK_NONE;
        ev         = EV_NONE;
        empty_line = 1'b0;
        line_ok    = 1'b0;
        r_cr       = '0;
        r_byte     = '0;
        ent.accepted = 1'b1;
        if (!(phase_next == PH_START || phase_next == PH_HEAD || phase_next == PH_BODY))
        begin
            ent.accepted = 1'b0;
        end
        else if (phase_next == PH_BODY)
        begin
            kind = FK_BODY;
            if (rem_next <= 64'd1)
            begin
                rem_next   = '0;
                phase_next = PH_DONE;
                ev         = EV_DONE;
            end
            else
                rem_next = rem_next - 64'd1;
        end
        else if (s_tdata == CH_LF)
        begin
            empty_line = (ll_next == '0) || ((ll_next == LL_W'(1)) && crp_next);
            if (phase_next == PH_START)
            begin
                line_ok = mode_reg ? ((st_next.start_part >= SP_THIRD)
                                      && (st_next.start_part <= SP_FIFTH))
                                   : (st_next.start_part >= SP_FIFTH);
                phase_next = line_ok ? PH_HEAD : PH_ERR;
                ev         = line_ok ? EV_START_END : EV_ERROR;
            end
            else if (empty_line)
            begin
                if (cl_next != '0)
                begin
                    rem_next   = cl_next;
                    phase_next = PH_BODY;
                    ev         = EV_BODY;
                end
                else
                begin
                    phase_next = PH_DONE;
                    ev         = EV_DONE;
                end
            end
            else if (st_next.hpart == HP_NAME)
            begin
                phase_next = PH_ERR;
                ev         = EV_ERROR;
            end
            else
            begin
                if ((st_next.nm_idx >= CL_EMPTY) && (st_next.nm_idx <= CL_BAD))
                    cl_next = ((st_next.nm_idx == CL_DIGITS) || (st_next.nm_idx == CL_STOP))
                              ? st_next.acc : 64'd0;
                ev = EV_HEADER;
            end
            ll_next          = '0;
            crp_next         = 1'b0;
            st_next.hpart    = HP_NAME;
            st_next.nm_idx   = '0;
            st_next.acc      = '0;
        end
        else
        begin
            // a held cr that is not followed by lf goes out as an ordinary byte
            if (crp_next)
            begin
                crp_next       = 1'b0;
                r_cr           = classify(st_next, phase_next == PH_START, mode_reg, CH_CR);
                st_next        = r_cr.st;
                ent.cr_valid   = 1'b1;
                ent.cr_kind    = r_cr.kind;
                ent.cr_version = version_out(st_next);
            end
            if (s_tdata == CH_CR)
                crp_next = 1'b1;
            else
            begin
                r_byte  = classify(st_next, phase_next == PH_START, mode_reg, s_tdata);
                st_next = r_byte.st;
                kind    = r_byte.kind;
            end
            if (ll_next >= LL_W'(MAX_LINE))
            begin
                phase_next = PH_ERR;
                ev         = EV_ERROR;
            end
            else
                ll_next = ll_next + LL_W'(1);
        end
        ent.kind       = kind;
        ent.data       = (kind != FK_NONE) ? s_tdata : 8'h00;
        ent.event_code = ev;
        ent.version    = version_out(st_next);
        ent.status     = st_next.status;
        ent.length     = cl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            ll_reg    <= '0;
            crp_reg   <= 1'b0;
            st_reg    <= '0;
            cl_reg    <= '0;
            rem_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            ll_reg    <= ll_next;
            crp_reg   <= crp_next;
            st_reg    <= st_next;
            cl_reg    <= cl_next;
            rem_reg   <= rem_next;
        end
    end

endmodule
`default_nettype wire

/* src/hmbp_queue.sv */
`default_nettype none
module hmbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hmbp_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output hmbp_pkg::entry_t  head_entry
);
    import hmbp_pkg::*;

    `include "assert_macros.svh"

    entry_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, head_valid, "pop from empty queue")
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + QCNT_W'(1), "push lost")

endmodule
`default_nettype wire

/* src/hmbp_back.sv */
`default_nettype none
module hmbp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  hmbp_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hmbp_pkg::beat_t   beat
);
    import hmbp_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   cr_done_reg, cr_done_next;
    beat_t  beat_reg, beat_next;
    logic   load;
    logic   cr_turn;

    assign load     = head_valid && (!out_valid_reg || m_tready);
    assign cr_turn  = head_entry.cr_valid && !cr_done_reg;
    assign pop      = load && !cr_turn;
    assign m_tvalid = out_valid_reg;
    assign beat     = beat_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        cr_done_next   = cr_done_reg;
        beat_next      = beat_reg;
        if (load)
        begin
            out_valid_next       = 1'b1;
            beat_next.status     = head_entry.status;
            beat_next.length     = head_entry.length;
            beat_next.accepted   = head_entry.accepted;
            if (cr_turn)
            begin
                // released cr beat ahead of the byte that caused it
                beat_next.kind       = head_entry.cr_kind;
                beat_next.data       = (head_entry.cr_kind != FK_NONE) ? CH_CR : 8'h00;
                beat_next.event_code = EV_NONE;
                beat_next.version    = head_entry.cr_version;
                beat_next.last       = 1'b0;
                cr_done_next         = 1'b1;
            end
            else
            begin
                beat_next.kind       = head_entry.kind;
                beat_next.data       = head_entry.data;
                beat_next.event_code = head_entry.event_code;
                beat_next.version    = head_entry.version;
                beat_next.last       = 1'b1;
                cr_done_next         = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cr_done_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cr_done_reg   <= cr_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

endmodule
`default_nettype wire

/* src/http_message_byte_parser.sv */
`default_nettype none
// Byte-wise HTTP/1.1 message parser. One byte enters per cycle on the slave side
// unless the four-entry queue is full; it separates the classifier from the output
// register, so input and output stall independently. Each byte gives one beat,
// except a byte that follows a held CR other than LF, which gives two (the released
// CR first). Accepted bytes pass through the queue into the output register.
// message_mode (cfg_wr_data) selects request (0) or status line (1) parsing.
module http_message_byte_parser #(
    parameter int MAX_LINE = 8192
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,   // message_mode
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,       // data_byte
    input  logic          s_tuser,       // new_message
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,       // out_byte, event_res, version_code, status_code,
                                         // body_length, accepted, zero pad
    output logic [3:0]    m_tuser,       // field_kind
    output logic          m_tlast        // last_result
);
    import hmbp_pkg::*;

    logic    push, q_full, pop, head_valid;
    entry_t  push_entry, head_entry;
    beat_t   beat;

    hmbp_front #(.MAX_LINE(MAX_LINE)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    hmbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    hmbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .beat       (beat)
    );

    assign m_tdata = {4'h0, beat.accepted, beat.length, beat.status, beat.version,
                      beat.event_code, beat.data};
    assign m_tuser = beat.kind;
    assign m_tlast = beat.last;

endmodule
`default_nettype wire

/* tb/sv/tb_http_message_byte_parser.sv */
module tb_http_message_byte_parser;
    import hmbp_pkg::*;

    typedef struct
    {
        logic [3:0]  kind;
        logic [7:0]  data;
        logic [2:0]  ev;
        logic [7:0]  version;
        logic [15:0] status;
        logic [63:0] length;
        logic        acc;
        logic        last;
    } beat_exp_t;

    class parse_scoreboard;
        beat_exp_t   pending_beats[$];
        int          errors;
        logic        mode;
        phase_t      phase;
        int unsigned line_len;
        logic [2:0]  part;
        logic        cr_held;
        logic [3:0]  vmaj;
        logic [7:0]  vmin;
        logic [3:0]  vchk;
        logic [15:0] status;
        logic [4:0]  nm_idx;
        logic [1:0]  hpart;
        logic [63:0] acc;
        logic [63:0] clen;
        logic [63:0] body_left;

        function new();
            errors = 0;
            mode = 1'b0;
            clear();
        endfunction

        function void clear();
            phase = PH_START;
            line_len = 0;
            part = SP_FIRST;
            cr_held = 1'b0;
            vmaj = 4'd0;
            vmin = 8'd0;
            vchk = 4'd0;
            status = 16'd0;
            nm_idx = 5'd0;
            hpart = HP_NAME;
            acc = 64'd0;
            clen = 64'd0;
            body_left = 64'd0;
        endfunction

        function bit digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function void push(logic [3:0] k, logic [7:0] b, logic [2:0] ev, logic a);
            beat_exp_t e;
            e.kind = k;
            e.data = (k != FK_NONE) ? b : 8'd0;
            e.ev = ev;
            e.version = (vchk == VC_OK) ? ({vmaj, 4'd0} | vmin) : 8'd0;
            e.status = status;
            e.length = clen;
            e.acc = a;
            e.last = 1'b0;
            pending_beats.insert(pending_beats.size(), e);
        endfunction

        function void feed_version(logic [7:0] b);
            logic [7:0] tag[5];
            tag = '{"H", "T", "T", "P", "/"};
            if (vchk < VC_TAG_DONE)
                vchk = (b == tag[vchk]) ? vchk + 4'd1 : VC_BAD;
            else if (vchk == VC_TAG_DONE)
            begin
                if (digit(b))
                begin
                    vmaj = 4'(b - "0");
                    vchk = VC_MAJOR;
                end
                else
                    vchk = VC_BAD;
            end
            else if (vchk == VC_MAJOR)
            begin
                if (digit(b))
                    vmaj = 4'(vmaj * 10 + (b - "0"));
                else
                    vchk = (b == ".") ? VC_DOT : VC_BAD;
            end
            else if (vchk == VC_DOT)
            begin
                if (digit(b))
                begin
                    vmin = b - "0";
                    vchk = VC_OK;
                end
                else
                    vchk = VC_BAD;
            end
            else if (vchk == VC_OK)
            begin
                if (digit(b))
                    vmin = vmin * 8'd10 + (b - "0");
                else
                    vchk = VC_BAD;
            end
        endfunction

        function logic [3:0] tag_byte(logic [7:0] b);
            logic [7:0] lc;
            logic [63:0] d;
            logic [7:0] cl[14];
            cl = '{"c","o","n","t","e","n","t","-","l","e","n","g","t","h"};
            d = b - "0";
            if (phase == PH_START && !mode)
            begin
                case (part)
                    SP_FIRST:
                    begin
                        if (b == " ") begin part = SP_SECOND; return FK_NONE; end
                        return FK_METHOD;
                    end
                    SP_SECOND:
                    begin
                        if (b == " ") begin part = SP_FIFTH; return FK_NONE; end
                        if (b == "?") begin part = SP_THIRD; return FK_NONE; end
                        if (b == "#") begin part = SP_FOURTH; return FK_NONE; end
                        return FK_PATH;
                    end
                    SP_THIRD:
                    begin
                        if (b == " ") begin part = SP_FIFTH; return FK_NONE; end
                        if (b == "#") begin part = SP_FOURTH; return FK_NONE; end
                        return FK_QUERY;
                    end
                    SP_FOURTH:
                    begin
                        if (b == " ") begin part = SP_FIFTH; return FK_NONE; end
                        return FK_FRAGMENT;
                    end
                    default:
                    begin
                        feed_version(b);
                        return FK_VERSION;
                    end
                endcase
            end
            if (phase == PH_START)
            begin
                case (part)
                    SP_FIRST:
                    begin
                        if (b == " ") begin part = SP_SECOND; return FK_NONE; end
                        feed_version(b);
                        return FK_VERSION;
                    end
                    SP_SECOND:
                    begin
                        if (b == " ") begin part = SP_LATE_REASON; return FK_NONE; end
                        if (digit(b))
                        begin
                            status = b - "0";
                            part = SP_THIRD;
                        end
                        else
                            part = SP_BAD_STATUS;
                        return FK_STATUS;
                    end
                    SP_THIRD:
                    begin
                        if (b == " ") begin part = SP_FIFTH; return FK_NONE; end
                        if (digit(b))
                            status = status * 16'd10 + (b - "0");
                        else
                            part = SP_FOURTH;
                        return FK_STATUS;
                    end
                    SP_FOURTH:
                    begin
                        if (b == " ") begin part = SP_FIFTH; return FK_NONE; end
                        return FK_STATUS;
                    end
                    SP_BAD_STATUS:
                    begin
                        if (b == " ") begin part = SP_LATE_REASON; return FK_NONE; end
                        return FK_STATUS;
                    end
                    default: return FK_REASON;
                endcase
            end
            if (hpart == HP_NAME)
            begin
                if (b == ":")
                begin
                    nm_idx = (nm_idx == CL_MATCHED) ? CL_EMPTY : NM_NONE;
                    hpart = HP_GAP;
                    return FK_NONE;
                end
                lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                if (nm_idx < CL_MATCHED)
                    nm_idx = (lc == cl[nm_idx]) ? nm_idx + 5'd1 : NM_NONE;
                else
                    nm_idx = NM_NONE;
                return FK_NAME;
            end
            if (hpart == HP_GAP && (b == " " || b == CH_TAB))
                return FK_NONE;
            hpart = HP_VALUE;
            if (nm_idx == CL_EMPTY)
            begin
                if (digit(b))
                begin
                    acc = d;
                    nm_idx = CL_DIGITS;
                end
                else
                    nm_idx = CL_BAD;
            end
            else if (nm_idx == CL_DIGITS)
            begin
                if (!digit(b))
                    nm_idx = CL_STOP;
                else if (acc > (64'hffff_ffff_ffff_ffff - d) / 10)
                    nm_idx = CL_BAD;
                else
                    acc = acc * 10 + d;
            end
            return FK_VALUE;
        endfunction

        function logic [2:0] close_line(bit blank);
            logic [2:0] ev;
            bit ok;
            if (phase == PH_START)
            begin
                ok = mode ? (part >= SP_THIRD && part <= SP_FIFTH) : (part >= SP_FIFTH);
                phase = ok ? PH_HEAD : PH_ERR;
                ev = ok ? EV_START_END : EV_ERROR;
            end
            else if (blank)
            begin
                if (clen > 0)
                begin
                    body_left = clen;
                    phase = PH_BODY;
                    ev = EV_BODY;
                end
                else
                begin
                    phase = PH_DONE;
                    ev = EV_DONE;
                end
            end
            else if (hpart == HP_NAME)
            begin
                phase = PH_ERR;
                ev = EV_ERROR;
            end
            else
            begin
                if (nm_idx >= CL_EMPTY && nm_idx <= CL_BAD)
                    clen = (nm_idx == CL_DIGITS || nm_idx == CL_STOP) ? acc : 64'd0;
                ev = EV_HEADER;
            end
            line_len = 0;
            cr_held = 1'b0;
            hpart = HP_NAME;
            nm_idx = 5'd0;
            acc = 64'd0;
            return ev;
        endfunction

        function void note_byte(logic [7:0] b, logic fresh);
            logic [3:0] k;
            logic [2:0] ev;
            if (fresh)
                clear();
            if (phase == PH_DONE || phase == PH_ERR)
                push(FK_NONE, 8'd0, EV_NONE, 1'b0);
            else if (phase == PH_BODY)
            begin
                ev = EV_NONE;
                if (body_left <= 1)
                begin
                    body_left = 0;
                    phase = PH_DONE;
                    ev = EV_DONE;
                end
                else
                    body_left--;
                push(FK_BODY, b, ev, 1'b1);
            end
            else if (b == CH_LF)
            begin
                ev = close_line(line_len == 0 || (line_len == 1 && cr_held));
                push(FK_NONE, 8'd0, ev, 1'b1);
            end
            else
            begin
                k = FK_NONE;
                ev = EV_NONE;
                if (cr_held)
                begin
                    cr_held = 1'b0;
                    k = tag_byte(CH_CR);
                    push(k, CH_CR, EV_NONE, 1'b1);
                    k = FK_NONE;
                end
                if (b == CH_CR)
                    cr_held = 1'b1;
                else
                    k = tag_byte(b);
                if (line_len + 1 > 8192)
                begin
                    phase = PH_ERR;
                    ev = EV_ERROR;
                end
                else
                    line_len++;
                push(k, b, ev, 1'b1);
            end
            pending_beats[$].last = 1'b1;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_beat(logic [3:0] k, logic [103:0] d, logic l);
            beat_exp_t e;
            if (pending_beats.size() == 0)
            begin
                report("beat with nothing expected");
                return;
            end
            e = pending_beats.pop_front();
            if (k !== e.kind || d[7:0] !== e.data || d[10:8] !== e.ev
                || d[18:11] !== e.version || d[34:19] !== e.status
                || d[98:35] !== e.length || d[99] !== e.acc || l !== e.last)
                report($sformatf("got k%0d d%h l%b, want k%0d b%h ev%0d v%h s%0d len%0d a%b l%b",
                    k, d, l, e.kind, e.data, e.ev, e.version, e.status, e.length,
                    e.acc, e.last));
        endtask
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    logic          cfg_wr_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [7:0]    s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [103:0]  m_tdata;   // out_byte, event_res, version_code, status_code,
                              // body_length, accepted, zero pad
    logic [3:0]    m_tuser;   // field_kind
    logic          m_tlast;

    parse_scoreboard sb;
    bit              calm;
    bit              stim_done;
    int              sent;

    http_message_byte_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    task send_byte(logic [7:0] b, logic fresh = 1'b0);
        while (!calm && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= fresh;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, fresh);
        sent++;
        @(negedge clk);
    endtask

    task send_text(string s, bit fresh);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fresh && i == 0);
    endtask

    task drain_and_set_mode(logic m);
        s_tvalid <= 1'b0;
        while (sb.pending_beats.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        sb.mode = m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function string rand_token(int n, string alpha);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(alpha[$urandom_range(alpha.len() - 1)])};
        return s;
    endfunction

    task send_message(bit resp);
        string line;
        int blen;
        if (resp)
            line = $sformatf("HTTP/%0d.%0d %0d %s\r\n", $urandom_range(12),
                $urandom_range(300), $urandom_range(99999), rand_token(3, "OKab z"));
        else
            line = $sformatf("%s /%s?%s#%s HTTP/1.%0d\r\n", rand_token(3, "GETPOS"),
                rand_token(3, "abc/"), rand_token(2, "x=&"), rand_token(2, "fg"),
                $urandom_range(9));
        if ($urandom_range(9) == 0)
            line = rand_token($urandom_range(1, 12), "AB /?#.1:\r\n");
        send_text(line, 1'b1);
        blen = 0;
        repeat ($urandom_range(3))
        begin
            if ($urandom_range(1))
            begin
                blen = $urandom_range(6);
                line = $sformatf("%s:%s%0d\r\n", $urandom_range(1) ? "Content-LENGTH"
                    : "content-length", $urandom_range(1) ? " \t" : "", blen);
                if ($urandom_range(7) == 0)
                    line = "content-length: 99999999999999999999x\r\n";
            end
            else
                line = $sformatf("%s: %s\r\n", rand_token(4, "Hostx-"),
                    rand_token(3, "a\r 9"));
            if ($urandom_range(15) == 0)
                line = "nocolon\n";
            send_text(line, 1'b0);
        end
        send_text($urandom_range(1) ? "\r\n" : "\n", 1'b0);
        repeat (blen + $urandom_range(2))
            send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        sb = new();
        calm = 1'b0;
        stim_done = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drain_and_set_mode(1'b0);
        send_text("GET /a?q#f HTTP/1.1\r\nContent-Length: 2\r\n\r\nxy", 1'b1);
        send_text("GE\rT  HTTP/1.1\n", 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff);
        send_byte(8'h0a);
        send_byte(8'h20);
        drain_and_set_mode(1'b1);
        send_text("HTTP/1.0 404 Not\r\nX\n", 1'b1);
        send_text("HTTP/1.1 x \r\n", 1'b1);
        send_text("HTTP/9.9  late\n\n", 1'b1);

        for (int n = 0; sent < 900; n++)
        begin
            if (n % 5 == 0)
                drain_and_set_mode(1'($urandom_range(1)));
            calm = (sent > 400 && sent < 520);
            if ($urandom_range(9) < 8)
                send_message(sb.mode);
            else
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= calm || $urandom_range(99) >= 30;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tuser, m_tdata, m_tlast);

    initial
    begin
        wait (stim_done);
        while (sb.pending_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
